// ===== sv/ogp_pkg.sv =====
package ogp_pkg;

    // Widths of the stream fields and the configuration port.
    localparam int OUT_ROW_W   = 10;
    localparam int OUT_COL_W   = 9;
    localparam int GRID_COLS_W = 10;
    localparam int GRID_ROWS_W = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int WIN_W       = 9;

    // Grid size after reset.
    localparam logic [GRID_COLS_W-1:0] GRID_COLS_RESET = 10'd401;
    localparam logic [GRID_ROWS_W-1:0] GRID_ROWS_RESET = 11'd401;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_COLS = 2'd0,
        REG_GRID_ROWS = 2'd1
    } ogp_cfg_reg_t;

    // One input beat.
    typedef struct packed {
        logic cell_req;
        logic flush;
    } ogp_in_t;

    // One result beat.
    typedef struct packed {
        logic                 padded;
        logic [OUT_ROW_W-1:0] out_row;
        logic [OUT_COL_W-1:0] out_col;
        logic                 last;
    } ogp_out_t;

    // Per-item control handed from the position tracker to the window stage.
    typedef struct packed {
        logic                 have;
        logic                 last;
        logic [WIN_W-1:0]     mask;
        logic                 top_row;
        logic                 second_row;
        logic                 v;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
    } ogp_ctrl_t;

endpackage

// ===== sv/ogp_pos_ctrl.sv =====
module ogp_pos_ctrl #(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 accept,
    input  logic                                 restart,
    input  ogp_pkg::ogp_in_t                     in_data,
    input  logic [$clog2(MAX_COLS):0]            cols_eff,
    input  logic [$clog2(MAX_ROWS):0]            rows_eff,
    output logic                                 enter,
    output logic [$clog2(MAX_COLS)-1:0]          addr,
    output ogp_pkg::ogp_ctrl_t                   ctrl
);

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CE_W   = COL_W + 1;
    localparam int ROW_W  = $clog2(MAX_ROWS) + 1;
    localparam int OROW_W = ogp_pkg::OUT_ROW_W;
    localparam int OCOL_W = ogp_pkg::OUT_COL_W;

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;

    logic             col_zero;
    logic             have;
    logic             col_end;
    logic             row_end;
    logic             wrap;
    logic [ROW_W-1:0] cr;
    logic [COL_W-1:0] cc;
    logic [CE_W-1:0]  cols_m1;
    logic [ROW_W-1:0] rows_m1;
    logic [CE_W-1:0]  col_inc;
    logic [2:0]       col_ok;
    logic [2:0]       row_ok;

    // Locate the window center, one row plus one cell behind the raster position.
    always_comb begin
        col_zero = (in_col_reg == '0);
        cols_m1  = cols_eff - CE_W'(1);
        rows_m1  = rows_eff - ROW_W'(1);
        cr       = col_zero ? (in_row_reg - ROW_W'(2)) : (in_row_reg - ROW_W'(1));
        cc       = col_zero ? cols_m1[COL_W-1:0] : (in_col_reg - COL_W'(1));
        have     = (col_zero ? (in_row_reg >= ROW_W'(2)) : (in_row_reg != '0))
                   && (cr < rows_eff);
        col_end  = ({1'b0, cc} == cols_m1);
        row_end  = (cr == rows_m1);
        col_inc  = {1'b0, in_col_reg} + CE_W'(1);
        wrap     = (col_inc >= cols_eff);
        enter    = !(in_data.flush && (in_row_reg < rows_eff));
    end

    // Neighbors outside the grid are masked off.
    always_comb begin
        col_ok = {!col_end, 1'b1, (cc != '0)};
        row_ok = {!row_end, 1'b1, (cr != '0)};
        for (int k = 0; k < 3; k++) begin
            for (int r = 0; r < 3; r++) begin
                ctrl.mask[k*3 + r] = col_ok[k] & row_ok[r];
            end
        end
        ctrl.have       = have;
        ctrl.last       = row_end && col_end;
        ctrl.top_row    = (in_row_reg == '0);
        ctrl.second_row = (in_row_reg == ROW_W'(1));
        ctrl.v          = in_data.flush | in_data.cell_req;
        ctrl.row        = OROW_W'(cr);
        ctrl.col        = OCOL_W'(cc);
        addr            = in_col_reg;
    end

    // Advance the raster position; the final result restarts the grid.
    always_comb begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        if (restart) begin
            in_col_next = '0;
            in_row_next = '0;
        end else if (accept && enter) begin
            if (have && ctrl.last) begin
                in_col_next = '0;
                in_row_next = '0;
            end else if (wrap) begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end else begin
                in_col_next = col_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg <= '0;
            in_row_reg <= '0;
        end else begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
        end
    end

`ifndef NO_ASSERTIONS
    // The column position always stays inside the current row.
    a_col_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, in_col_reg} < cols_eff)
        else $error("column position beyond row length");

    // The row position never passes the end of the drain.
    a_row_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        in_row_reg <= rows_eff + ROW_W'(1))
        else $error("row position beyond drain point");

    // The beat that yields the final result restarts the position.
    a_last_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && enter && have && ctrl.last |=> in_row_reg == '0 && in_col_reg == '0)
        else $error("position not restarted after final result");
`endif

endmodule

// ===== sv/ogp_window.sv =====
module ogp_window #(
    parameter int MAX_COLS = 512
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  logic [$clog2(MAX_COLS)-1:0] addr_in,
    input  ogp_pkg::ogp_ctrl_t          ctrl_in,
    input  logic                        out_free,
    output logic                        s1_ready,
    output logic                        res_valid,
    output ogp_pkg::ogp_out_t           res
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int WIN_W = ogp_pkg::WIN_W;

    // Line store: bit 0 holds the previous row, bit 1 the row before it.
    logic [1:0]         line_mem [MAX_COLS];

    logic               s1_valid_reg, s1_valid_next;
    logic               fwd_reg;
    logic [1:0]         fwd_data_reg;
    logic [1:0]         rdata_reg;
    logic [COL_W-1:0]   s1_addr_reg;
    ogp_pkg::ogp_ctrl_t s1_ctrl_reg;
    logic [WIN_W-1:0]   window_reg, window_next;

    logic               s1_adv;
    logic [1:0]         ls_raw;
    logic [1:0]         ls;
    logic [1:0]         wr_data;
    logic [2:0]         colvec;

    // Merge the line store read with a write-back to the same entry one beat ahead.
    always_comb begin
        s1_adv  = s1_valid_reg && (!s1_ctrl_reg.have || out_free);
        s1_ready = !s1_valid_reg || s1_adv;
        ls_raw  = fwd_reg ? fwd_data_reg : rdata_reg;
        // Rows above the grid read as free until they have been written.
        if (s1_ctrl_reg.top_row) begin
            ls = 2'b11;
        end else if (s1_ctrl_reg.second_row) begin
            ls = {1'b1, ls_raw[0]};
        end else begin
            ls = ls_raw;
        end
        wr_data     = {ls[0], s1_ctrl_reg.v};
        colvec      = {s1_ctrl_reg.v, ls[0], ls[1]};
        window_next = {colvec, window_reg[WIN_W-1:3]};
    end

    // Padded value and result fields.
    always_comb begin
        res_valid   = s1_adv && s1_ctrl_reg.have;
        res.padded  = &(window_next | ~s1_ctrl_reg.mask);
        res.out_row = s1_ctrl_reg.row;
        res.out_col = s1_ctrl_reg.col;
        res.last    = s1_ctrl_reg.last;
    end

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (load) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    // Memory read on load and write-back when the stage advances.
    always_ff @(posedge aclk) begin
        if (load) begin
            rdata_reg <= line_mem[addr_in];
        end
        if (s1_adv) begin
            line_mem[s1_addr_reg] <= wr_data;
        end
    end

    // Stage payload.
    always_ff @(posedge aclk) begin
        if (load) begin
            s1_addr_reg  <= addr_in;
            s1_ctrl_reg  <= ctrl_in;
            fwd_data_reg <= wr_data;
        end
    end

    // Stage control and the sliding window.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            window_reg   <= '1;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (load) begin
                fwd_reg <= s1_valid_reg && (addr_in == s1_addr_reg);
            end
            if (s1_adv) begin
                window_reg <= window_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A result is only produced when the output register can take it.
    a_res_room: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result produced into a full output register");

    // A new item only enters when the stage is free or moving on.
    a_load_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> s1_ready)
        else $error("item loaded into a blocked stage");

    // A stalled stage keeps its entry and its window.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_addr_reg)
            && $stable(window_reg))
        else $error("stalled stage lost its contents");
`endif

endmodule

// ===== sv/occupancy_grid_obstacle_padding_top.sv =====
// Result order: the result for a cell is formed from the beat grid_cols + 1 after it, which
// passes the window stage and then the output register.
// Throughput: one beat per cycle while the output register can take results, set by the
// line store reading one entry and writing back another in the same cycle.
// Reset: position restarts at zero and the grid size returns to 401 x 401; the line store
// needs no clearing pass because the first two rows mask what it holds.
module occupancy_grid_obstacle_padding_top #(
    parameter int MAX_COLS = 512,
    parameter int MAX_ROWS = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  ogp_pkg::ogp_in_t                     s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output ogp_pkg::ogp_out_t                    m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [ogp_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [ogp_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int CE_W  = COL_W + 1;
    localparam int ROW_W = $clog2(MAX_ROWS) + 1;
    localparam int GC_W  = ogp_pkg::GRID_COLS_W;
    localparam int GR_W  = ogp_pkg::GRID_ROWS_W;
    localparam int CX_W  = (CE_W > GC_W) ? CE_W : GC_W;
    localparam int RX_W  = (ROW_W > GR_W) ? ROW_W : GR_W;

    logic [GC_W-1:0]    grid_cols_reg, grid_cols_next;
    logic [GR_W-1:0]    grid_rows_reg, grid_rows_next;
    logic               m_valid_reg, m_valid_next;
    ogp_pkg::ogp_out_t  m_data_reg;

    logic               cfg_fire;
    logic               restart;
    logic               s_fire;
    logic               enter;
    logic               out_free;
    logic               s1_ready;
    logic               res_valid;
    ogp_pkg::ogp_out_t  res;
    ogp_pkg::ogp_ctrl_t ctrl;
    logic [COL_W-1:0]   addr;
    logic [CX_W-1:0]    gc_x;
    logic [RX_W-1:0]    gr_x;
    logic [CE_W-1:0]    cols_eff;
    logic [ROW_W-1:0]   rows_eff;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_ready   = s1_ready;
    assign s_fire    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Register writes; a size write restarts the grid. Other indexes are ignored.
    always_comb begin
        grid_cols_next = grid_cols_reg;
        grid_rows_next = grid_rows_reg;
        restart        = 1'b0;
        if (cfg_fire) begin
            unique case (cfg_index)
                ogp_pkg::REG_GRID_COLS: begin
                    grid_cols_next = cfg_data[GC_W-1:0];
                    restart        = 1'b1;
                end
                ogp_pkg::REG_GRID_ROWS: begin
                    grid_rows_next = cfg_data[GR_W-1:0];
                    restart        = 1'b1;
                end
                default: begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    // Grid size saturated to the supported range.
    always_comb begin
        gc_x = CX_W'(grid_cols_reg);
        gr_x = RX_W'(grid_rows_reg);
        if (gc_x == '0) begin
            cols_eff = CE_W'(1);
        end else if (gc_x > CX_W'(MAX_COLS)) begin
            cols_eff = CE_W'(MAX_COLS);
        end else begin
            cols_eff = CE_W'(gc_x);
        end
        if (gr_x == '0) begin
            rows_eff = ROW_W'(1);
        end else if (gr_x > RX_W'(MAX_ROWS)) begin
            rows_eff = ROW_W'(MAX_ROWS);
        end else begin
            rows_eff = ROW_W'(gr_x);
        end
    end

    // Output register.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg <= ogp_pkg::GRID_COLS_RESET;
            grid_rows_reg <= ogp_pkg::GRID_ROWS_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            grid_cols_reg <= grid_cols_next;
            grid_rows_reg <= grid_rows_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= res;
        end
    end

    ogp_pos_ctrl #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_pos_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (s_fire),
        .restart  (restart),
        .in_data  (s_data),
        .cols_eff (cols_eff),
        .rows_eff (rows_eff),
        .enter    (enter),
        .addr     (addr),
        .ctrl     (ctrl)
    );

    ogp_window #(
        .MAX_COLS (MAX_COLS)
    ) u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (s_fire && enter),
        .addr_in   (addr),
        .ctrl_in   (ctrl),
        .out_free  (out_free),
        .s1_ready  (s1_ready),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_MAX_COLS = 512;
    localparam int GRID_MAX_ROWS = 1024;
    localparam int DRAIN_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 80;
    localparam int CYCLE_LIMIT   = 400000;

    // How a directed step is used and how its result is checked.
    typedef enum logic [1:0] {
        STEP_COLS,
        STEP_ROWS,
        STEP_BEAT
    } step_kind_t;

    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_TYPED
    } chk_t;

    typedef struct {
        step_kind_t                     kind;
        logic [ogp_pkg::CFG_DATA_W-1:0] data;
        ogp_pkg::ogp_in_t               beat;
        chk_t                           chk;
        ogp_pkg::ogp_out_t              want;
    } dir_step_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    ogp_pkg::ogp_in_t                s_data;
    logic                            m_valid;
    logic                            m_ready;
    ogp_pkg::ogp_out_t               m_data;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [ogp_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [ogp_pkg::CFG_DATA_W-1:0]  cfg_data;

    // Erosion predictor state: the two previous rows per column, the 3x3 window,
    // the raster position of the next beat and the size registers.
    logic [1:0]                      pad_lines [GRID_MAX_COLS];
    logic [ogp_pkg::WIN_W-1:0]       pad_win;
    int unsigned                     pos_row;
    int unsigned                     pos_col;
    logic [ogp_pkg::GRID_COLS_W-1:0] cols_reg;
    logic [ogp_pkg::GRID_ROWS_W-1:0] rows_reg;

    ogp_pkg::ogp_out_t pad_expected [$];
    dir_step_t         dir_steps [$];
    int unsigned       items_sent;
    int unsigned       error_count;
    int unsigned       cycle_count;
    int unsigned       tx_idle_pct;
    int unsigned       rx_idle_pct;
    int unsigned       hold_requests;
    int unsigned       holds_done;

    occupancy_grid_obstacle_padding_top #(
        .MAX_COLS(GRID_MAX_COLS),
        .MAX_ROWS(GRID_MAX_ROWS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("occupancy_grid_obstacle_padding_top regression: fail");
        $finish;
    end

    // Sizes as the block uses them, saturated to the legal range.
    function automatic int unsigned grid_cols_eff();
        if (cols_reg == 0) return 1;
        if (cols_reg > GRID_MAX_COLS) return GRID_MAX_COLS;
        return cols_reg;
    endfunction

    function automatic int unsigned grid_rows_eff();
        if (rows_reg == 0) return 1;
        if (rows_reg > GRID_MAX_ROWS) return GRID_MAX_ROWS;
        return rows_reg;
    endfunction

    function automatic void pad_reset();
        foreach (pad_lines[i]) pad_lines[i] = 2'b11;
        pad_win  = '1;
        pos_row  = 0;
        pos_col  = 0;
        cols_reg = ogp_pkg::GRID_COLS_RESET;
        rows_reg = ogp_pkg::GRID_ROWS_RESET;
    endfunction

    // Advances the predictor by one accepted beat. The result, if any, belongs to the
    // cell one row plus one cell behind the current raster position.
    function automatic void pad_step(input ogp_pkg::ogp_in_t beat, output bit has,
                                     output ogp_pkg::ogp_out_t res, output bit ignored);
        int unsigned cols;
        int unsigned rows;
        int unsigned cr;
        int unsigned cc;
        logic        v;
        logic [1:0]  ls;
        cols    = grid_cols_eff();
        rows    = grid_rows_eff();
        has     = 1'b0;
        ignored = 1'b0;
        res     = '0;
        cr      = 0;
        cc      = 0;
        if (pos_col >= cols) begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row > rows + 1) begin
            pos_row = 0;
            pos_col = 0;
        end
        // A flush while real cells are still due is dropped.
        if (beat.flush && pos_row < rows) begin
            ignored = 1'b1;
            return;
        end
        v  = beat.flush ? 1'b1 : beat.cell_req;
        ls = pad_lines[pos_col];
        pad_win = {v, ls[0], ls[1], pad_win[ogp_pkg::WIN_W-1:3]};
        pad_lines[pos_col] = {ls[0], v};
        if (pos_col == 0) begin
            if (pos_row >= 2) begin
                cr  = pos_row - 2;
                cc  = cols - 1;
                has = 1'b1;
            end
        end else if (pos_row >= 1) begin
            cr  = pos_row - 1;
            cc  = pos_col - 1;
            has = 1'b1;
        end
        if (has && cr >= rows) has = 1'b0;
        pos_col++;
        if (pos_col >= cols) begin
            pos_col = 0;
            pos_row++;
        end
        if (!has) return;
        // Neighbors outside the grid are masked; the rest must all be free.
        res.padded = 1'b1;
        for (int k = 0; k < 3; k++) begin
            for (int r = 0; r < 3; r++) begin
                if ((k == 0 && cc < 1) || (k == 2 && cc + 1 >= cols) ||
                    (r == 0 && cr < 1) || (r == 2 && cr + 1 >= rows)) continue;
                if (!pad_win[k * 3 + r]) res.padded = 1'b0;
            end
        end
        res.out_row = cr[ogp_pkg::OUT_ROW_W-1:0];
        res.out_col = cc[ogp_pkg::OUT_COL_W-1:0];
        res.last    = (cr == rows - 1) && (cc == cols - 1);
        if (res.last) begin
            pos_row = 0;
            pos_col = 0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Offers one input beat, with random gaps in front, and records what it should cause.
    task automatic send_beat(input ogp_pkg::ogp_in_t beat, input chk_t chk = CHK_MODEL,
                             input ogp_pkg::ogp_out_t want = '0);
        bit                has;
        bit                ignored;
        ogp_pkg::ogp_out_t res;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pad_step(beat, has, res, ignored);
        if (chk == CHK_TYPED) pad_expected.insert(pad_expected.size(), want);
        else if (chk == CHK_MODEL && has) pad_expected.insert(pad_expected.size(), res);
        if (!ignored) items_sent++;
    endtask

    // Lets every expected result arrive, then gives the pipeline time to settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pad_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes the size registers while the block is idle.
    task automatic write_regs(input bit do_cols,
                              input logic [ogp_pkg::CFG_DATA_W-1:0] cols_val,
                              input bit do_rows,
                              input logic [ogp_pkg::CFG_DATA_W-1:0] rows_val);
        ogp_pkg::ogp_cfg_reg_t idx;
        wait_drained();
        for (int i = 0; i < 2; i++) begin
            if (i == 0 ? do_cols : do_rows) begin
                idx = (i == 0) ? ogp_pkg::REG_GRID_COLS : ogp_pkg::REG_GRID_ROWS;
                cfg_valid <= 1'b1;
                cfg_index <= idx;
                cfg_data  <= (i == 0) ? cols_val : rows_val;
                @(posedge aclk);
                while (!cfg_ready) @(posedge aclk);
                unique case (idx)
                    ogp_pkg::REG_GRID_COLS: cols_reg = cols_val[ogp_pkg::GRID_COLS_W-1:0];
                    ogp_pkg::REG_GRID_ROWS: rows_reg = rows_val;
                    default: ;
                endcase
                pos_row = 0;
                pos_col = 0;
            end
        end
        cfg_valid <= 1'b0;
    endtask

    // Streams one grid at the current size and drains its last row. With noise, ignored
    // flush beats fall inside the grid and real cells fall into the drain. A cut stops
    // the grid early.
    task automatic run_grid(input int unsigned free_pct, input bit noisy, input int cut);
        int unsigned      cols;
        int unsigned      cells;
        ogp_pkg::ogp_in_t beat;
        cols  = grid_cols_eff();
        cells = cols * grid_rows_eff();
        for (int i = 0; i < cells; i++) begin
            if (i == cut) return;
            if (noisy && $urandom_range(99) < 5) begin
                beat.cell_req = 1'($urandom_range(1));
                beat.flush    = 1'b1;
                send_beat(beat);
            end
            beat.cell_req = ($urandom_range(99) < free_pct);
            beat.flush    = 1'b0;
            send_beat(beat);
        end
        for (int j = 0; j <= cols; j++) begin
            beat.flush    = !(noisy && $urandom_range(99) < 20);
            beat.cell_req = 1'($urandom_range(1));
            send_beat(beat);
        end
    endtask

    // Result side: random backpressure, one long hold on request, and the check of
    // each accepted beat against the oldest expectation.
    initial begin
        ogp_pkg::ogp_out_t want;
        int unsigned       hold_left;
        m_ready   = 1'b0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pad_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected result at row %0d col %0d",
                                              m_data.out_row, m_data.out_col));
                end else begin
                    want = pad_expected.pop_front();
                    if (m_data.padded !== want.padded)
                        report_mismatch($sformatf("padded %b, want %b (row %0d col %0d)",
                                                  m_data.padded, want.padded,
                                                  want.out_row, want.out_col));
                    if (m_data.out_row !== want.out_row)
                        report_mismatch($sformatf("out_row %0d, want %0d",
                                                  m_data.out_row, want.out_row));
                    if (m_data.out_col !== want.out_col)
                        report_mismatch($sformatf("out_col %0d, want %0d",
                                                  m_data.out_col, want.out_col));
                    if (m_data.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b (row %0d col %0d)",
                                                  m_data.last, want.last,
                                                  want.out_row, want.out_col));
                end
            end
            if (hold_left == 0 && holds_done != hold_requests) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Stimulus and end of run.
    initial begin
        int unsigned                    c;
        int unsigned                    r;
        int unsigned                    free_pct;
        int unsigned                    phase_end;
        int                             cut;
        bit                             resize;
        logic [ogp_pkg::CFG_DATA_W-1:0] craw;
        logic [ogp_pkg::CFG_DATA_W-1:0] rraw;

        s_valid       = 1'b0;
        s_data        = '0;
        cfg_valid     = 1'b0;
        cfg_index     = ogp_pkg::REG_GRID_COLS;
        cfg_data      = '0;
        aresetn       = 1'b0;
        items_sent    = 0;
        error_count   = 0;
        tx_idle_pct   = 23;
        rx_idle_pct   = 66;
        hold_requests = 0;
        holds_done    = 0;
        pad_reset();

        // Beats are {cell_req, flush}; results are {padded, out_row, out_col, last}.
        dir_steps = '{
            // Reset size of 401 x 401: the first row gives nothing, a flush is dropped.
            '{STEP_BEAT, '0, {1'b1, 1'b0}, CHK_NONE, '0},
            '{STEP_BEAT, '0, {1'b0, 1'b1}, CHK_NONE, '0},
            '{STEP_BEAT, '0, {1'b0, 1'b0}, CHK_NONE, '0},
            // Zero sizes saturate to a single cell, whose result is its own value.
            '{STEP_COLS, 11'd0, '0, CHK_NONE, '0},
            '{STEP_ROWS, 11'd0, '0, CHK_NONE, '0},
            '{STEP_BEAT, '0, {1'b1, 1'b0}, CHK_NONE, '0},
            '{STEP_BEAT, '0, {1'b0, 1'b1}, CHK_NONE, '0},
            '{STEP_BEAT, '0, {1'b0, 1'b1}, CHK_TYPED, {1'b1, 10'd0, 9'd0, 1'b1}},
            // A real cell after the grid end starts the next grid; a second one only drains, its value unused.
            '{STEP_BEAT, '0, {1'b0, 1'b0}, CHK_NONE, '0},
            '{STEP_BEAT, '0, {1'b1, 1'b0}, CHK_NONE, '0},
            '{STEP_BEAT, '0, {1'b0, 1'b1}, CHK_TYPED, {1'b0, 10'd0, 9'd0, 1'b1}},
            // Column register keeps ten bits: the top data bit is dropped, giving 3 x 3.
            '{STEP_COLS, 11'h403, '0, CHK_NONE, '0},
            '{STEP_ROWS, 11'd3, '0, CHK_NONE, '0},
            '{STEP_BEAT, '0, {1'b1, 1'b0}, CHK_MODEL, '0},
            '{STEP_BEAT, '0, {1'b1, 1'b0}, CHK_MODEL, '0},
            '{STEP_BEAT, '0, {1'b1, 1'b0}, CHK_MODEL, '0},
            '{STEP_BEAT, '0, {1'b1, 1'b0}, CHK_MODEL, '0},
            '{STEP_BEAT, '0, {1'b1, 1'b1}, CHK_MODEL, '0},
            '{STEP_BEAT, '0, {1'b1, 1'b0}, CHK_MODEL, '0},
            '{STEP_BEAT, '0, {1'b0, 1'b0}, CHK_MODEL, '0},
            '{STEP_BEAT, '0, {1'b1, 1'b0}, CHK_MODEL, '0},
            '{STEP_BEAT, '0, {1'b1, 1'b0}, CHK_MODEL, '0},
            '{STEP_BEAT, '0, {1'b1, 1'b0}, CHK_MODEL, '0},
            '{STEP_BEAT, '0, {1'b0, 1'b1}, CHK_MODEL, '0},
            '{STEP_BEAT, '0, {1'b0, 1'b1}, CHK_MODEL, '0},
            '{STEP_BEAT, '0, {1'b0, 1'b1}, CHK_MODEL, '0},
            '{STEP_BEAT, '0, {1'b0, 1'b1}, CHK_MODEL, '0}
        };

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed steps.
        foreach (dir_steps[i]) begin
            case (dir_steps[i].kind)
                STEP_COLS: write_regs(1'b1, dir_steps[i].data, 1'b0, '0);
                STEP_ROWS: write_regs(1'b0, '0, 1'b1, dir_steps[i].data);
                default:   send_beat(dir_steps[i].beat, dir_steps[i].chk, dir_steps[i].want);
            endcase
        end

        // Random grids under three idling mixes.
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 66 : 0;
            rx_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 23 : 0;
            phase_end   = items_sent + PHASE_ITEMS;
            if (ph == 0) begin
                // The receiver holds off while this grid streams in, so the block backs up.
                write_regs(1'b1, 11'd8, 1'b1, 11'd12);
                hold_requests++;
                run_grid(90, 1'b0, -1);
            end
            resize = 1'b1;
            while (items_sent < phase_end) begin
                if (resize || $urandom_range(99) < 60) begin
                    c = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
                    r = $urandom_range(8, 1);
                    craw = (c == 1 && $urandom_range(1) == 1) ?
                           11'd0 : c[ogp_pkg::CFG_DATA_W-1:0];
                    if ($urandom_range(99) < 20) craw[ogp_pkg::CFG_DATA_W-1] = 1'b1;
                    rraw = (r == 1 && $urandom_range(1) == 1) ?
                           11'd0 : r[ogp_pkg::CFG_DATA_W-1:0];
                    write_regs(resize || $urandom_range(3) != 0, craw, 1'b1, rraw);
                end
                case ($urandom_range(2))
                    0:       free_pct = 60;
                    1:       free_pct = 85;
                    default: free_pct = 97;
                endcase
                cut = ($urandom_range(99) < 10) ?
                      int'($urandom_range(grid_cols_eff() * grid_rows_eff())) : -1;
                run_grid(free_pct, $urandom_range(99) < 40, cut);
                resize = (cut >= 0);
            end
        end

        // Register values beyond the legal range saturate; these grids are cut short.
        write_regs(1'b1, 11'h7FF, 1'b1, 11'd0);
        run_grid(97, 1'b0, 40);
        write_regs(1'b1, 11'd2, 1'b1, 11'h7FF);
        run_grid(95, 1'b0, 40);

        wait_drained();
        if (error_count == 0) begin
            $display("occupancy_grid_obstacle_padding_top regression: pass");
        end else begin
            $display("occupancy_grid_obstacle_padding_top regression: fail");
        end
        $finish;
    end

endmodule
